// File: rtl/fca_pkg.sv
// fca_pkg: shared types and codes for the fat chain allocator
// command and result structs, op and status codes, table constants
// no dependencies
package fca_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int IDX_W          = 16;
    localparam int CNT_W          = 13;
    localparam int STEP_W         = 13;
    localparam int OP_W           = 3;
    localparam int ST_W           = 2;

    localparam logic [IDX_W-1:0] LINK_END = 16'hFFFF;
    localparam logic [IDX_W-1:0] LINK_FREE = 16'h0000;
    localparam logic [CNT_W-1:0] DBC_RESET = 13'd4096;

    localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OP_W-1:0] OP_WALK  = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  block_index;
        logic [IDX_W-1:0]  entry_value;
        logic [STEP_W-1:0] step_count;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [CNT_W-1:0] free_count;
        logic [ST_W-1:0]  status;
    } result_t;

endpackage

// File: rtl/fat_chain_allocator.sv
// fat_chain_allocator: link table with allocate, free, walk, count, load, read
// one table memory and one sequencer shared by all operations
// depends on fca_pkg
//
// usage:
//   a command transfers when start is high and busy is low; busy stays high
//   until the result is produced. each command gives exactly one result,
//   shown on result for one cycle with done high; the receiver cannot stall.
//   data block count register: written through cfg_valid/cfg_ready/cfg_data,
//   ready always high; write it only while the block is idle (not enforced).
// sequencing, through the one read port of the table memory:
//   load, unknown op, bad allocate or read index: answered in the idle state
//   read: one table read, then the result
//   allocate: scan from index 1 to the first free entry, then link it in
//   count free: scan from index 0; both scans stop at data block count
//   free chain: read then clear each link; walk: follow one link per step
// reset: clears control and sets the data block count to 4096; table
// contents are undefined until loaded.
module fat_chain_allocator #(
    parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fca_pkg::cmd_t               cmd,
    output logic                        done,
    output fca_pkg::result_t            result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fca_pkg::CNT_W-1:0]   cfg_data
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int IW = fca_pkg::IDX_W;
    localparam int CW = fca_pkg::CNT_W;
    localparam logic [IW:0] NB_L = (IW+1)'(NUM_BLOCKS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_ALINK   = 4'd2;
    localparam logic [3:0] S_ATAIL   = 4'd3;
    localparam logic [3:0] S_FREE_RD = 4'd4;
    localparam logic [3:0] S_FREE_WR = 4'd5;
    localparam logic [3:0] S_WALK    = 4'd6;
    localparam logic [3:0] S_WALK_W  = 4'd7;
    localparam logic [3:0] S_READ    = 4'd8;

    logic [IW-1:0] mem [NUM_BLOCKS];
    logic [IW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [IW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [3:0]            state_reg, state_next;
    logic [fca_pkg::OP_W-1:0] op_reg, op_next;
    logic [IW-1:0]         cur_reg, cur_next;
    logic [IW-1:0]         lim_reg, lim_next;
    logic                  over_reg, over_next;
    logic [IW-1:0]         iter_reg, iter_next;
    logic [IW-1:0]         ptr_reg, ptr_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IW-1:0]         chk_ptr_reg, chk_ptr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         dbc_reg;
    logic                  done_reg, done_next;
    fca_pkg::result_t      result_reg, result_next;

    logic [IW:0] used_n;
    logic [IW:0] steps_ext;
    logic        cur_oob;
    logic        idx_oob;

    assign used_n    = ({{(IW+1-CW){1'b0}}, dbc_reg} > NB_L) ? NB_L
                       : {{(IW+1-CW){1'b0}}, dbc_reg};
    assign steps_ext = {{(IW+1-fca_pkg::STEP_W){1'b0}}, cmd.step_count};
    assign cur_oob   = ({1'b0, cur_reg} >= NB_L);
    assign idx_oob   = ({1'b0, cmd.block_index} >= NB_L);

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cur_next     = cur_reg;
        lim_next     = lim_reg;
        over_next    = over_reg;
        iter_next    = iter_reg;
        ptr_next     = ptr_reg;
        chk_vld_next = chk_vld_reg;
        chk_ptr_next = chk_ptr_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_waddr    = cur_reg[AW-1:0];
        mem_wdata    = fca_pkg::LINK_FREE;
        mem_raddr    = cur_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next                  = cmd.op;
                    cur_next                 = cmd.block_index;
                    iter_next                = '0;
                    chk_vld_next             = 1'b0;
                    cnt_next                 = '0;
                    result_next.result_index = '0;
                    result_next.free_count   = '0;
                    result_next.status       = fca_pkg::ST_OK;
                    unique case (cmd.op)
                        fca_pkg::OP_ALLOC:
                        begin
                            if (cmd.block_index != fca_pkg::LINK_END && idx_oob)
                            begin
                                result_next.status = fca_pkg::ST_BAD;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = IW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        fca_pkg::OP_FREE:
                        begin
                            state_next = S_FREE_RD;
                        end
                        fca_pkg::OP_WALK:
                        begin
                            lim_next   = (steps_ext > NB_L) ? NB_L[IW-1:0]
                                         : steps_ext[IW-1:0];
                            over_next  = (steps_ext > NB_L);
                            state_next = S_WALK;
                        end
                        fca_pkg::OP_COUNT:
                        begin
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                        fca_pkg::OP_LOAD:
                        begin
                            if (idx_oob)
                            begin
                                result_next.status = fca_pkg::ST_BAD;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cmd.block_index[AW-1:0];
                                mem_wdata = cmd.entry_value;
                            end
                            done_next = 1'b1;
                        end
                        fca_pkg::OP_READ:
                        begin
                            if (idx_oob)
                            begin
                                result_next.status = fca_pkg::ST_BAD;
                                done_next          = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = cmd.block_index[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            result_next.status = fca_pkg::ST_BAD;
                            done_next          = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_raddr = ptr_reg[AW-1:0];
                if (chk_vld_reg && op_reg == fca_pkg::OP_ALLOC
                    && rd_data_reg == fca_pkg::LINK_FREE)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = S_ALINK;
                end
                else
                begin
                    if (chk_vld_reg && rd_data_reg == fca_pkg::LINK_FREE)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if ({1'b0, ptr_reg} < used_n)
                    begin
                        chk_vld_next = 1'b1;
                        chk_ptr_next = ptr_reg;
                        ptr_next     = ptr_reg + IW'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        if (!chk_vld_reg)
                        begin
                            if (op_reg == fca_pkg::OP_ALLOC)
                            begin
                                result_next.status = fca_pkg::ST_FULL;
                            end
                            else
                            begin
                                result_next.free_count = cnt_reg;
                            end
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_ALINK:
            begin
                mem_we                   = 1'b1;
                mem_waddr                = chk_ptr_reg[AW-1:0];
                mem_wdata                = fca_pkg::LINK_END;
                result_next.result_index = chk_ptr_reg;
                if (cur_reg == fca_pkg::LINK_END)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ATAIL;
                end
            end
            S_ATAIL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg[AW-1:0];
                mem_wdata  = chk_ptr_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_FREE_RD:
            begin
                if (cur_reg == fca_pkg::LINK_END)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if ({1'b0, iter_reg} == NB_L || cur_oob)
                begin
                    result_next.status = fca_pkg::ST_BAD;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = fca_pkg::LINK_FREE;
                cur_next   = rd_data_reg;
                iter_next  = iter_reg + IW'(1);
                state_next = S_FREE_RD;
            end
            S_WALK:
            begin
                if (iter_reg == lim_reg)
                begin
                    result_next.result_index = cur_reg;
                    result_next.status = over_reg ? fca_pkg::ST_BAD : fca_pkg::ST_OK;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cur_oob)
                begin
                    result_next.result_index = cur_reg;
                    result_next.status       = fca_pkg::ST_BAD;
                    done_next                = 1'b1;
                    state_next               = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK_W;
                end
            end
            S_WALK_W:
            begin
                cur_next   = rd_data_reg;
                iter_next  = iter_reg + IW'(1);
                state_next = S_WALK;
            end
            S_READ:
            begin
                result_next.result_index = rd_data_reg;
                done_next                = 1'b1;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            chk_vld_reg <= 1'b0;
            dbc_reg     <= fca_pkg::DBC_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            chk_vld_reg <= chk_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                dbc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cur_reg     <= cur_next;
        lim_reg     <= lim_next;
        over_reg    <= over_next;
        iter_reg    <= iter_next;
        ptr_reg     <= ptr_next;
        chk_ptr_reg <= chk_ptr_next;
        cnt_reg     <= cnt_next;
        result_reg  <= result_next;
    end

    // scan only runs for allocate and count
    a_scan_op: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> (op_reg == fca_pkg::OP_ALLOC || op_reg == fca_pkg::OP_COUNT))
        else $error("scan with wrong op");

    // a full table reports no index and no count
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.status == fca_pkg::ST_FULL
        |-> result_reg.result_index == '0 && result_reg.free_count == '0)
        else $error("full result carries data");

    // free count only comes from the count op
    a_count_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && result_reg.free_count != '0 |-> op_reg == fca_pkg::OP_COUNT)
        else $error("free count from wrong op");

    // walk step counter never passes its limit
    a_walk_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_WALK_W) |-> iter_reg <= lim_reg)
        else $error("walk passed step limit");

endmodule

// File: dv/fat_chain_checker.sv
`timescale 1ns / 1ps
// fat_chain_checker: link table predictor and result comparator for the allocator
// watches the command, result and data block count channels, keeps a failure count
// depends on fca_pkg
module fat_chain_checker #(
    parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  fca_pkg::cmd_t             cmd,
    input  logic                      done,
    input  fca_pkg::result_t          result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [fca_pkg::CNT_W-1:0] cfg_data,
    output int                        errors,
    output int                        open_results
);
    import fca_pkg::*;

    localparam int MSG_CAP = 40;

    logic [IDX_W-1:0] links [NUM_BLOCKS];
    int unsigned blocks_setting = DBC_RESET;
    result_t due_results [$];
    int fail_tally = 0;

    function automatic result_t run_table_op(input cmd_t c);
        result_t r;
        int unsigned n;
        int unsigned idx;
        int unsigned steps;
        int unsigned cur;
        int unsigned nxt;
        int unsigned lim;
        int unsigned cnt;
        int unsigned i;
        r = '0;
        r.status = ST_OK;
        idx = c.block_index;
        steps = c.step_count;
        n = (blocks_setting > NUM_BLOCKS) ? NUM_BLOCKS : blocks_setting;
        case (c.op)
            OP_ALLOC:
            begin
                if (idx != LINK_END && idx >= NUM_BLOCKS)
                begin
                    r.status = ST_BAD;
                end
                else
                begin
                    cur = 0;
                    for (i = 1; i < n; i++)
                    begin
                        if (links[i] == LINK_FREE)
                        begin
                            cur = i;
                            break;
                        end
                    end
                    if (cur == 0)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        links[cur] = LINK_END;
                        if (idx != LINK_END)
                            links[idx] = cur[IDX_W-1:0];
                        r.result_index = cur[IDX_W-1:0];
                    end
                end
            end
            OP_FREE:
            begin
                cur = idx;
                for (i = 0; i < NUM_BLOCKS && cur != LINK_END; i++)
                begin
                    if (cur >= NUM_BLOCKS)
                        break;
                    nxt = links[cur];
                    links[cur] = LINK_FREE;
                    cur = nxt;
                end
                if (cur != LINK_END)
                    r.status = ST_BAD;
            end
            OP_WALK:
            begin
                cur = idx;
                lim = (steps > NUM_BLOCKS) ? NUM_BLOCKS : steps;
                for (i = 0; i < lim; i++)
                begin
                    if (cur >= NUM_BLOCKS)
                    begin
                        r.status = ST_BAD;
                        break;
                    end
                    cur = links[cur];
                end
                // a walk longer than the table can only end inside a loop
                if (r.status == ST_OK && steps > NUM_BLOCKS)
                    r.status = ST_BAD;
                r.result_index = cur[IDX_W-1:0];
            end
            OP_COUNT:
            begin
                cnt = 0;
                for (i = 0; i < n; i++)
                begin
                    if (links[i] == LINK_FREE)
                        cnt++;
                end
                if (cnt > 8191)
                    cnt = 8191;
                r.free_count = cnt[CNT_W-1:0];
            end
            OP_LOAD:
            begin
                if (idx < NUM_BLOCKS)
                    links[idx] = c.entry_value;
                else
                    r.status = ST_BAD;
            end
            OP_READ:
            begin
                if (idx < NUM_BLOCKS)
                    r.result_index = links[idx];
                else
                    r.status = ST_BAD;
            end
            default:
            begin
                r.status = ST_BAD;
            end
        endcase
        return r;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        fail_tally++;
        if (fail_tally <= MSG_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic compare_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            fail_tally++;
            if (fail_tally <= MSG_CAP)
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end
        else
        begin
            want = due_results.pop_front();
            if (got.result_index !== want.result_index)
                report_field("result_index", want.result_index, got.result_index);
            if (got.free_count !== want.free_count)
                report_field("free_count", want.free_count, got.free_count);
            if (got.status !== want.status)
                report_field("status", want.status, got.status);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result never lands on the edge of its own command transfer
            if (done)
                compare_result(result);
            if (start && !busy)
                due_results.push_back(run_table_op(cmd));
            if (cfg_valid && cfg_ready)
                blocks_setting = cfg_data;
        end
        errors <= fail_tally;
        open_results <= due_results.size();
    end

endmodule

// File: dv/fat_chain_allocator_test.sv
`timescale 1ns / 1ps
// fat_chain_allocator_test: top of the allocator testbench, drives commands and
// data block count writes, builds chains at random and gives the verdict
// depends on fca_pkg, fat_chain_allocator and fat_chain_checker
module fat_chain_allocator_test;
    import fca_pkg::*;

    localparam int NBLK = NUM_BLOCKS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             done;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    int      errors;
    int      open_results;
    int      sent = 0;
    int      done_seen = 0;
    result_t last_result = '0;
    int      idle_cycles = 0;
    bit      no_idle = 1'b0;

    int chain_head [$];
    int chain_tail [$];
    int chain_len [$];

    int block_settings [7] = '{1, 2, 17, 300, 8191, 4096, 40};
    int phase_items [7] = '{10, 10, 35, 30, 10, 10, 35};

    fat_chain_allocator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    fat_chain_checker u_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .errors(errors),
        .open_results(open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            done_seen <= done_seen + 1;
            last_result <= result;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic cmd_t make_cmd(input logic [OP_W-1:0] op,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [IDX_W-1:0] val,
                                      input logic [STEP_W-1:0] steps);
        cmd_t c;
        c.op = op;
        c.block_index = idx;
        c.entry_value = val;
        c.step_count = steps;
        return c;
    endfunction

    function automatic logic [IDX_W-1:0] any_value();
        return IDX_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [STEP_W-1:0] any_steps();
        return STEP_W'($urandom_range(0, 8191));
    endfunction

    // one command transfer; optionally hold off until its result is back
    task automatic send(input cmd_t c, input bit need_result);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        sent++;
        if (need_result)
        begin
            start <= 1'b0;
            while (done_seen != sent)
                @(posedge clk);
        end
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic [IDX_W-1:0] val, input logic [STEP_W-1:0] steps);
        send(make_cmd(op, idx, val, steps), 1'b0);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (done_seen != sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_block_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= CNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // negative chain number starts a new chain
    task automatic alloc_append(input int chain);
        logic [IDX_W-1:0] tail;
        tail = (chain < 0) ? LINK_END : IDX_W'(chain_tail[chain]);
        send(make_cmd(OP_ALLOC, tail, any_value(), any_steps()), 1'b1);
        if (last_result.status == ST_OK)
        begin
            if (chain < 0)
            begin
                chain_head.push_back(last_result.result_index);
                chain_tail.push_back(last_result.result_index);
                chain_len.push_back(1);
            end
            else
            begin
                chain_tail[chain] = last_result.result_index;
                chain_len[chain] = chain_len[chain] + 1;
            end
        end
    endtask

    task automatic random_item();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            if (chain_head.size() > 0 && $urandom_range(0, 2) != 0)
                alloc_append($urandom_range(0, chain_head.size() - 1));
            else
                alloc_append(-1);
        end
        else if (pick < 42)
        begin
            if (chain_head.size() > 0)
            begin
                k = $urandom_range(0, chain_head.size() - 1);
                issue(OP_FREE, IDX_W'(chain_head[k]), any_value(), any_steps());
                chain_head.delete(k);
                chain_tail.delete(k);
                chain_len.delete(k);
            end
            else
            begin
                issue(OP_FREE, LINK_END, any_value(), any_steps());
            end
        end
        else if (pick < 57)
        begin
            if (chain_head.size() > 0)
            begin
                k = $urandom_range(0, chain_head.size() - 1);
                issue(OP_WALK, IDX_W'(chain_head[k]), any_value(),
                      STEP_W'($urandom_range(0, chain_len[k] + 1)));
            end
            else
            begin
                issue(OP_WALK, LINK_END, any_value(), STEP_W'($urandom_range(0, 3)));
            end
        end
        else if (pick < 67)
        begin
            issue(OP_COUNT, any_value(), any_value(), any_steps());
        end
        else if (pick < 80)
        begin
            issue(OP_READ, IDX_W'($urandom_range(0, NBLK - 1)), any_value(), any_steps());
        end
        else
        begin
            // noise: stray loads, unknown ops, wild indices
            case ($urandom_range(0, 4))
                0: issue(OP_LOAD, IDX_W'($urandom_range(0, NBLK - 1)), any_value(), any_steps());
                1: issue($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, any_value(),
                         any_value(), any_steps());
                2:
                begin
                    case ($urandom_range(0, 2))
                        0: issue(OP_ALLOC, any_value(), any_value(), any_steps());
                        1: issue(OP_READ, any_value(), any_value(), any_steps());
                        default: issue(OP_LOAD, any_value(), any_value(), any_steps());
                    endcase
                end
                3: issue(OP_WALK, any_value(), any_value(), STEP_W'($urandom_range(0, 3)));
                default: issue(OP_FREE, IDX_W'($urandom_range(0, NBLK - 1)), any_value(),
                               any_steps());
            endcase
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry gets loaded before anything reads the table
        no_idle = 1'b1;
        for (int i = 0; i < NBLK; i++)
            issue(OP_LOAD, IDX_W'(i), (i == 0) ? LINK_END : LINK_FREE, any_steps());
        no_idle = 1'b0;

        issue(OP_ALLOC, LINK_END, any_value(), any_steps());
        issue(OP_ALLOC, 16'd1, any_value(), any_steps());
        issue(OP_ALLOC, 16'd2, any_value(), any_steps());
        issue(OP_WALK, 16'd1, any_value(), 13'd0);
        issue(OP_WALK, LINK_END, any_value(), 13'd0);
        issue(OP_WALK, 16'd1, any_value(), 13'd2);
        issue(OP_WALK, 16'd1, any_value(), 13'd4);
        issue(OP_READ, 16'd4096, any_value(), any_steps());
        issue(OP_LOAD, LINK_END, 16'h1234, any_steps());
        issue(OP_ALLOC, 16'd4096, any_value(), any_steps());
        issue(OP_ALLOC, 16'hFFFE, any_value(), any_steps());
        issue(OP_COUNT, any_value(), any_value(), any_steps());
        issue(OP_FREE, 16'd1, any_value(), any_steps());
        issue(OP_FREE, 16'd5000, any_value(), any_steps());
        issue(OP_SPARE_A, any_value(), any_value(), any_steps());
        // free stops at an out of range link after clearing the head
        issue(OP_LOAD, 16'd8, 16'd5000, any_steps());
        issue(OP_FREE, 16'd8, any_value(), any_steps());
        // self loop walked past the table size
        issue(OP_LOAD, 16'd5, 16'd5, any_steps());
        issue(OP_WALK, 16'd5, any_value(), 13'd8191);
        issue(OP_FREE, 16'd5, any_value(), any_steps());
        issue(OP_WALK, LINK_END, any_value(), 13'd8191);
        // entry 0 is now free, so this pair frees into an endless loop
        issue(OP_LOAD, 16'd6, 16'd7, any_steps());
        issue(OP_LOAD, 16'd7, 16'd6, any_steps());
        issue(OP_FREE, 16'd6, any_value(), any_steps());
        issue(OP_LOAD, 16'd0, LINK_END, any_steps());

        for (int p = 0; p < 7; p++)
        begin
            write_block_count(block_settings[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (phase_items[p]) random_item();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && open_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/fca_pkg.sv
rtl/fat_chain_allocator.sv
dv/fat_chain_checker.sv
dv/fat_chain_allocator_test.sv
